[hw/rtl/ddp_pkg.sv]
// ----------------------------------------------------------------------------
// ddp_pkg
// Shared types, constants and helpers of the DSD to DoP packer.
// ----------------------------------------------------------------------------
`default_nettype none

package ddp_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_LSB_FIRST     = 2'd0;
    localparam logic [1:0] CFG_CHANNEL_COUNT = 2'd1;

    // reset values of the configuration registers
    localparam logic       LSB_FIRST_RST     = 1'b0;
    localparam logic [3:0] CHANNEL_COUNT_RST = 4'd2;

    // DoP marker bytes
    localparam logic [7:0] MARKER_LOW  = 8'h05;
    localparam logic [7:0] MARKER_HIGH = 8'hfa;

    // control flags from the sequencer to the datapath
    typedef struct packed {
        logic hold_en;      // store first byte of the pair
        logic sample_en;    // second byte: emit a DoP sample
        logic is_last;      // current position is the last channel
        logic marker_high;  // current marker phase
        logic second_half;  // second bytes are arriving
    } seq_ctl_t;

    // one result word
    typedef struct packed {
        logic [23:0] dop_sample;
        logic [2:0]  channel_index;
        logic        frame_last;
    } out_item_t;

    // reverse the bit order of one byte (swap nibbles, pairs, bits)
    function automatic logic [7:0] flip_byte(input logic [7:0] v);
        logic [7:0] t;
        begin
            t = ((v & 8'hf0) >> 4) | ((v & 8'h0f) << 4);
            t = ((t & 8'hcc) >> 2) | ((t & 8'h33) << 2);
            t = ((t & 8'haa) >> 1) | ((t & 8'h55) << 1);
            return t;
        end
    endfunction

endpackage

`default_nettype wire

[hw/rtl/ddp_ram.sv]
// ----------------------------------------------------------------------------
// ddp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ddp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                                   clk,
    input  wire logic                                   wr_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                       wr_data,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

[hw/rtl/ddp_sequencer.sv]
// ----------------------------------------------------------------------------
// ddp_sequencer
// Channel position, pair half and marker phase of the DoP stream.
// ----------------------------------------------------------------------------
`default_nettype none

module ddp_sequencer #(
    parameter int MAX_CHANNELS = 8,
    parameter int POS_W        = 3
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [3:0]       channel_count,
    input  wire logic             step,
    input  wire logic             eos,
    output ddp_pkg::seq_ctl_t     ctl,
    output logic      [POS_W-1:0] pos,
    output logic      [POS_W-1:0] pos_next
);

    localparam int CNT_W = 7;

    logic [POS_W-1:0] pos_reg;
    logic             half_reg;
    logic             half_next;
    logic             marker_reg;
    logic             marker_next;
    logic [CNT_W-1:0] active_cnt;
    logic [CNT_W-1:0] last_ch;
    logic             is_last;

    // clamp the channel count to one..MAX_CHANNELS
    always_comb
    begin
        priority if (channel_count == 4'd0)
        begin
            active_cnt = CNT_W'(1);
        end
        else if (CNT_W'(channel_count) > CNT_W'(MAX_CHANNELS))
        begin
            active_cnt = CNT_W'(MAX_CHANNELS);
        end
        else
        begin
            active_cnt = CNT_W'(channel_count);
        end
        last_ch = active_cnt - CNT_W'(1);
        is_last = CNT_W'(pos_reg) >= last_ch;
    end

    // next state
    always_comb
    begin
        pos_next    = pos_reg;
        half_next   = half_reg;
        marker_next = marker_reg;
        if (step)
        begin
            priority if (eos)
            begin
                pos_next  = '0;
                half_next = 1'b0;
            end
            else if (is_last)
            begin
                pos_next  = '0;
                half_next = ~half_reg;
                if (half_reg)
                begin
                    marker_next = ~marker_reg;
                end
            end
            else
            begin
                pos_next = pos_reg + POS_W'(1);
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            half_reg   <= 1'b0;
            marker_reg <= 1'b0;
        end
        else
        begin
            pos_reg    <= pos_next;
            half_reg   <= half_next;
            marker_reg <= marker_next;
        end
    end

    // control flags
    always_comb
    begin
        ctl.hold_en     = step && !eos && !half_reg;
        ctl.sample_en   = step && !eos && half_reg;
        ctl.is_last     = is_last;
        ctl.marker_high = marker_reg;
        ctl.second_half = half_reg;
    end

    assign pos = pos_reg;

endmodule

`default_nettype wire

[hw/rtl/ddp_out_reg.sv]
// ----------------------------------------------------------------------------
// ddp_out_reg
// Output register of the result stream; takes a new word when empty or while
// the held one is being taken.
// ----------------------------------------------------------------------------
`default_nettype none

module ddp_out_reg (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               load,
    input  ddp_pkg::out_item_t      item,
    output logic                    space,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic      [23:0]        m_tdata,   // dop_sample
    output logic      [2:0]         m_tuser,   // channel_index
    output logic                    m_tlast    // frame_last
);

    logic               valid_reg;
    logic               valid_next;
    ddp_pkg::out_item_t item_reg;

    // room for a new word when empty or the held word leaves now
    assign space = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        priority if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = item_reg.dop_sample;
    assign m_tuser  = item_reg.channel_index;
    assign m_tlast  = item_reg.frame_last;

endmodule

`default_nettype wire

[hw/rtl/dsd_to_dop_packer_core.sv]
// ----------------------------------------------------------------------------
// dsd_to_dop_packer_core
// Packs channel-interleaved DSD bytes into 24-bit DoP samples.
// ----------------------------------------------------------------------------
// output: a DoP sample appears on the output in the cycle after its second byte is accepted
// throughput: one input word per cycle while the output is not stalled; the output register
//   takes a new word in the same cycle that the held one is taken
// reset: rst_n clears position, pair half, marker phase (0x05 first), the
//   configuration registers and output valid; held first bytes are undefined until written
`default_nettype none

module dsd_to_dop_packer_core #(
    parameter int MAX_CHANNELS = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [3:0]  cfg_data,
    // DSD byte stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // dsd_byte
    input  wire logic        s_tuser,   // action
    // DoP sample stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [23:0] m_tdata,   // dop_sample
    output logic      [2:0]  m_tuser,   // channel_index
    output logic             m_tlast    // frame_last
);

    localparam int POS_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int WIDE_W = 7;

    logic               lsb_first_reg;
    logic [3:0]         channel_count_reg;
    logic               s_accept;
    logic               space;
    logic [7:0]         byte_in;
    ddp_pkg::seq_ctl_t  ctl;
    logic [POS_W-1:0]   pos;
    logic [POS_W-1:0]   pos_next;
    logic [WIDE_W-1:0]  pos_wide;
    logic [7:0]         ram_rd;
    logic               byp_hit_reg;
    logic [7:0]         byp_data_reg;
    logic [7:0]         held_byte;
    ddp_pkg::out_item_t item;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lsb_first_reg     <= ddp_pkg::LSB_FIRST_RST;
            channel_count_reg <= ddp_pkg::CHANNEL_COUNT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == ddp_pkg::CFG_LSB_FIRST)
            begin
                lsb_first_reg <= cfg_data[0];
            end
            else if (cfg_index == ddp_pkg::CFG_CHANNEL_COUNT)
            begin
                channel_count_reg <= cfg_data;
            end
        end
    end

    // input handshake
    assign s_tready = space;
    assign s_accept = s_tvalid && s_tready;

    // optional bit reversal
    assign byte_in = lsb_first_reg ? ddp_pkg::flip_byte(s_tdata) : s_tdata;

    ddp_sequencer #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .POS_W        (POS_W)
    ) u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .channel_count (channel_count_reg),
        .step          (s_accept),
        .eos           (s_tuser),
        .ctl           (ctl),
        .pos           (pos),
        .pos_next      (pos_next)
    );

    // held first bytes, read ahead at the next position
    ddp_ram #(
        .WIDTH (8),
        .DEPTH (MAX_CHANNELS)
    ) u_held (
        .clk     (clk),
        .wr_en   (ctl.hold_en),
        .wr_addr (pos),
        .wr_data (byte_in),
        .rd_addr (pos_next),
        .rd_data (ram_rd)
    );

    // forward a byte written at the address being read ahead
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_hit_reg <= 1'b0;
        end
        else
        begin
            byp_hit_reg <= ctl.hold_en && (pos == pos_next);
        end
    end

    always_ff @(posedge clk)
    begin
        byp_data_reg <= byte_in;
    end

    assign held_byte = byp_hit_reg ? byp_data_reg : ram_rd;

    // pack the DoP sample
    assign pos_wide = WIDE_W'(pos);

    always_comb
    begin
        item.dop_sample    = {(ctl.marker_high ? ddp_pkg::MARKER_HIGH : ddp_pkg::MARKER_LOW),
                              held_byte, byte_in};
        item.channel_index = pos_wide[2:0];
        item.frame_last    = ctl.is_last;
    end

    ddp_out_reg u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (ctl.sample_en),
        .item     (item),
        .space    (space),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // an empty output register never blocks the input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output register");

    // position stays inside the held byte store
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        WIDE_W'(pos) < WIDE_W'(MAX_CHANNELS))
        else $error("channel position beyond channel store");

    // end of stream rewinds position and pair half
    a_eos_rewind: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && s_tuser) |=> (pos == '0 && !ctl.second_half))
        else $error("end of stream did not rewind");

    // marker flips only after the last channel's sample
    a_marker_flip: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.sample_en && ctl.is_last) |=> (ctl.marker_high != $past(ctl.marker_high)))
        else $error("marker did not flip at frame end");

    // a sample loaded into the output is shown next cycle
    a_sample_shown: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.sample_en |=> m_tvalid)
        else $error("sample lost at output register");

endmodule

`default_nettype wire
